// ===== rtl/core/fdtd_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and register codes for the 1-D FDTD field update block.
// Used by every module under rtl/core except fdtd_ram; depends on nothing.

package fdtd_pkg;

   // Grid size and field formats
   localparam int CELLS      = 256;
   localparam int IDX_W      = $clog2(CELLS);
   localparam int DATA_W     = 32;
   localparam int GAIN_W     = 24;
   localparam int CELL_W     = 8;
   localparam int FRAC_BITS  = 20;

   // Update arithmetic widths: exact difference, exact product, rounded increment
   localparam int DIFF_W     = DATA_W + 1;
   localparam int PROD_W     = DIFF_W + GAIN_W + 1;
   localparam int INC_W      = PROD_W - FRAC_BITS;
   localparam int SUM_W      = INC_W + 1;

   // Sweep schedule: interleaved H and E update slots for every cell plus pipeline fill and drain
   localparam int SWEEP_LAST = 2 * CELLS + 7;
   localparam int CNT_W      = $clog2(SWEEP_LAST + 1);

   // Register port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef logic [1:0] reg_idx_type;
   localparam reg_idx_type REG_H_GAIN   = 2'd0;
   localparam reg_idx_type REG_E_GAIN   = 2'd1;
   localparam reg_idx_type REG_SRC_CELL = 2'd2;

   localparam logic [GAIN_W-1:0] H_GAIN_RST   = GAIN_W'(1048576);
   localparam logic [GAIN_W-1:0] E_GAIN_RST   = GAIN_W'(1048576);
   localparam logic [CELL_W-1:0] SRC_CELL_RST = CELL_W'(50);

   // Gain of exactly 1.0, used to pass the source value through the unit
   localparam logic [GAIN_W-1:0] UNITY_GAIN   = GAIN_W'(1 << FRAC_BITS);

   typedef logic [IDX_W-1:0]    idx_type;
   typedef logic [CNT_W-1:0]    cnt_type;
   typedef logic [CNT_W-2:0]    pair_type;
   typedef logic [DATA_W-1:0]   data_type;

   typedef struct packed {
      logic [GAIN_W-1:0] h_gain;
      logic [GAIN_W-1:0] e_gain;
      logic [CELL_W-1:0] source_cell;
   } cfg_type;

   // One operation for the shared update unit: base + round(diff * gain / 2^20)
   typedef struct packed {
      logic              vld;
      logic [DIFF_W-1:0] diff;
      logic [GAIN_W-1:0] gain;
      logic [DATA_W-1:0] base;
   } alu_req_type;

   typedef struct packed {
      logic              vld;
      logic [DATA_W-1:0] value;
      logic              clip;
   } alu_rsp_type;

   typedef struct packed {
      logic [DATA_W-1:0] electric;
      logic [DATA_W-1:0] magnetic;
      logic              saturated;
   } result_type;

endpackage

// ===== rtl/core/fdtd_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Standalone; one instance holds the electric and one the magnetic cell array.

module fdtd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/fdtd_alu.sv =====
`timescale 1ns / 1ps
// Shared two-stage update unit: multiply, round half up, add to base, saturate.
// Depends on fdtd_pkg for widths and the request/response structs.

module fdtd_alu (
   input  logic                  clock,
   input  logic                  reset,
   input  fdtd_pkg::alu_req_type req,
   output fdtd_pkg::alu_rsp_type rsp
);

   logic signed [fdtd_pkg::PROD_W-1:0] diff_x;
   logic signed [fdtd_pkg::PROD_W-1:0] gain_x;
   logic signed [fdtd_pkg::PROD_W-1:0] prod_in;
   logic signed [fdtd_pkg::PROD_W-1:0] prod_ff;
   logic [fdtd_pkg::DATA_W-1:0]        base_ff;
   logic                               vld1_ff;

   logic [fdtd_pkg::PROD_W-1:0]        rnd;
   logic [fdtd_pkg::INC_W-1:0]         inc;
   logic [fdtd_pkg::SUM_W-1:0]         sum;
   logic                               over;
   logic                               under;
   logic [fdtd_pkg::DATA_W-1:0]        value_in;
   logic [fdtd_pkg::DATA_W-1:0]        value_ff;
   logic                               clip_ff;
   logic                               vld2_ff;

   // Stage 1: exact product of the 33-bit difference and the unsigned gain
   assign diff_x  = {{(fdtd_pkg::PROD_W - fdtd_pkg::DIFF_W){req.diff[fdtd_pkg::DIFF_W-1]}},
                     req.diff};
   assign gain_x  = {{(fdtd_pkg::PROD_W - fdtd_pkg::GAIN_W){1'b0}}, req.gain};
   assign prod_in = diff_x * gain_x;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      base_ff <= req.base;
   end

   // Stage 2: floor((p + 2^19) / 2^20), add, clamp to 32 bits
   assign rnd = prod_ff + fdtd_pkg::PROD_W'(1 << (fdtd_pkg::FRAC_BITS - 1));
   assign inc = rnd[fdtd_pkg::PROD_W-1:fdtd_pkg::FRAC_BITS];
   assign sum = {{(fdtd_pkg::SUM_W - fdtd_pkg::DATA_W){base_ff[fdtd_pkg::DATA_W-1]}}, base_ff}
              + {inc[fdtd_pkg::INC_W-1], inc};

   assign over  = !sum[fdtd_pkg::SUM_W-1]
                && (sum[fdtd_pkg::SUM_W-2:fdtd_pkg::DATA_W-1] != '0);
   assign under = sum[fdtd_pkg::SUM_W-1]
                && (sum[fdtd_pkg::SUM_W-2:fdtd_pkg::DATA_W-1] != '1);

   always_comb begin
      value_in = sum[fdtd_pkg::DATA_W-1:0];
      if (over) begin
         value_in = {1'b0, {(fdtd_pkg::DATA_W-1){1'b1}}};
      end else if (under) begin
         value_in = {1'b1, {(fdtd_pkg::DATA_W-1){1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      clip_ff  <= over | under;
   end

   // valid pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
      end else begin
         vld1_ff <= req.vld;
         vld2_ff <= vld1_ff;
      end
   end

   assign rsp.vld   = vld2_ff;
   assign rsp.value = value_ff;
   assign rsp.clip  = clip_ff & vld2_ff;

endmodule

// ===== rtl/core/fdtd_csr.sv =====
`timescale 1ns / 1ps
// APB-style register file: h_gain, e_gain and source_cell.
// Depends on fdtd_pkg for register codes, reset values and cfg_type.

module fdtd_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [fdtd_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [fdtd_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [fdtd_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready,
   output fdtd_pkg::cfg_type                   cfg
);

   logic [fdtd_pkg::GAIN_W-1:0] h_gain_ff;
   logic [fdtd_pkg::GAIN_W-1:0] e_gain_ff;
   logic [fdtd_pkg::CELL_W-1:0] src_cell_ff;
   fdtd_pkg::reg_idx_type       reg_idx;
   logic                        wr_stb;

   assign reg_idx = paddr[fdtd_pkg::CSR_ADDR_W-1:2];
   assign wr_stb  = psel & penable & pwrite;
   assign pready  = 1'b1;

   // register writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         h_gain_ff   <= fdtd_pkg::H_GAIN_RST;
         e_gain_ff   <= fdtd_pkg::E_GAIN_RST;
         src_cell_ff <= fdtd_pkg::SRC_CELL_RST;
      end else if (wr_stb) begin
         case (reg_idx)
            fdtd_pkg::REG_H_GAIN: begin
               h_gain_ff <= pwdata[fdtd_pkg::GAIN_W-1:0];
            end
            fdtd_pkg::REG_E_GAIN: begin
               e_gain_ff <= pwdata[fdtd_pkg::GAIN_W-1:0];
            end
            fdtd_pkg::REG_SRC_CELL: begin
               src_cell_ff <= pwdata[fdtd_pkg::CELL_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // read mux
   always_comb begin
      case (reg_idx)
         fdtd_pkg::REG_H_GAIN:   prdata = fdtd_pkg::CSR_DATA_W'(h_gain_ff);
         fdtd_pkg::REG_E_GAIN:   prdata = fdtd_pkg::CSR_DATA_W'(e_gain_ff);
         fdtd_pkg::REG_SRC_CELL: prdata = fdtd_pkg::CSR_DATA_W'(src_cell_ff);
         default:                prdata = '0;
      endcase
   end

   assign cfg.h_gain      = h_gain_ff;
   assign cfg.e_gain      = e_gain_ff;
   assign cfg.source_cell = src_cell_ff;

endmodule

// ===== rtl/core/fdtd_seq.sv =====
`timescale 1ns / 1ps
// Sequencer and cell storage: clearing pass, fused H/E sweep, source add, probe read.
// Depends on fdtd_pkg and fdtd_ram; drives the shared update unit through alu_req/alu_rsp.

module fdtd_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  fdtd_pkg::cfg_type             cfg,
   input  logic                          item_valid,
   output logic                          item_ready,
   input  logic                          item_advance,
   input  logic [fdtd_pkg::DATA_W-1:0]   item_source,
   input  logic [fdtd_pkg::CELL_W-1:0]   item_probe,
   output logic                          out_valid,
   input  logic                          out_ready,
   output fdtd_pkg::result_type          out_data,
   output fdtd_pkg::alu_req_type         alu_req,
   input  fdtd_pkg::alu_rsp_type         alu_rsp
);

   typedef enum logic [8:0] {
      ST_CLEAR    = 9'b000000001,
      ST_IDLE     = 9'b000000010,
      ST_SWEEP    = 9'b000000100,
      ST_SRC_RD   = 9'b000001000,
      ST_SRC_OP   = 9'b000010000,
      ST_SRC_WAIT = 9'b000100000,
      ST_SRC_WR   = 9'b001000000,
      ST_PRB_RD   = 9'b010000000,
      ST_DONE     = 9'b100000000
   } state_type;

   state_type                     state_ff, state_in;
   fdtd_pkg::cnt_type             cnt_ff, cnt_in;
   logic                          adv_ff, adv_in;
   fdtd_pkg::data_type            src_ff, src_in;
   logic [fdtd_pkg::CELL_W-1:0]   prb_ff, prb_in;
   logic                          sat_ff, sat_in;

   // old electric values of the cells around the sweep position
   fdtd_pkg::data_type            e0_ff, e1_ff, e2_ff;
   // new magnetic values of the current and previous cell
   fdtd_pkg::data_type            hcur_ff, hprev_ff;

   fdtd_pkg::pair_type            pair;
   logic [31:0]                   pair32;
   logic                          odd;
   logic                          sweep;
   logic                          e_rd_sw, h_rd_sw;
   logic                          h_op, h_pass, e_op, e_pass;
   logic                          h_wr_sw, e_wr_sw;
   logic                          src_ok, prb_ok;
   fdtd_pkg::idx_type             sc_idx, prb_idx;

   logic                          e_wr_en, e_rd_en, h_wr_en, h_rd_en;
   fdtd_pkg::idx_type             e_wr_addr, e_rd_addr, h_wr_addr, h_rd_addr;
   fdtd_pkg::data_type            e_wr_data, h_wr_data, e_rd_data, h_rd_data;

   function automatic logic [fdtd_pkg::DIFF_W-1:0] diff_of(
      input logic [fdtd_pkg::DATA_W-1:0] hi,
      input logic [fdtd_pkg::DATA_W-1:0] lo
   );
      diff_of = {hi[fdtd_pkg::DATA_W-1], hi} - {lo[fdtd_pkg::DATA_W-1], lo};
   endfunction

   // Sweep slot decode. Slot pairs p = cnt/2: odd slots read E[p], H[p-1], issue E updates
   // and retire E results; even slots issue H updates and retire H results.
   assign pair    = cnt_ff[fdtd_pkg::CNT_W-1:1];
   assign pair32  = 32'(pair);
   assign odd     = cnt_ff[0];
   assign sweep   = (state_ff == ST_SWEEP);

   assign e_rd_sw = sweep & odd & (pair32 < 32'(fdtd_pkg::CELLS));
   assign h_rd_sw = sweep & odd & (pair32 >= 32'd1) & (pair32 <= 32'(fdtd_pkg::CELLS));
   assign h_op    = sweep & !odd & (pair32 >= 32'd2) & (pair32 <= 32'(fdtd_pkg::CELLS + 1));
   assign h_pass  = (pair32 == 32'(fdtd_pkg::CELLS + 1));
   assign e_op    = sweep & odd & (pair32 >= 32'd3) & (pair32 <= 32'(fdtd_pkg::CELLS + 2));
   assign e_pass  = (pair32 == 32'd3);
   assign h_wr_sw = sweep & !odd & (pair32 >= 32'd3) & (pair32 <= 32'(fdtd_pkg::CELLS + 2));
   assign e_wr_sw = sweep & odd & (pair32 >= 32'd4) & (pair32 <= 32'(fdtd_pkg::CELLS + 3));

   assign src_ok  = 32'(cfg.source_cell) < 32'(fdtd_pkg::CELLS);
   assign prb_ok  = 32'(prb_ff) < 32'(fdtd_pkg::CELLS);
   assign sc_idx  = fdtd_pkg::idx_type'(cfg.source_cell);
   assign prb_idx = fdtd_pkg::idx_type'(prb_ff);

   // Electric RAM port control
   always_comb begin
      e_wr_en   = 1'b0;
      e_wr_addr = fdtd_pkg::idx_type'(pair32 - 32'd4);
      e_wr_data = alu_rsp.value;
      e_rd_en   = 1'b0;
      e_rd_addr = fdtd_pkg::idx_type'(pair32);
      case (state_ff)
         ST_CLEAR: begin
            e_wr_en   = 1'b1;
            e_wr_addr = fdtd_pkg::idx_type'(cnt_ff);
            e_wr_data = '0;
         end
         ST_SWEEP: begin
            e_wr_en = e_wr_sw;
            e_rd_en = e_rd_sw;
         end
         ST_SRC_RD: begin
            e_rd_en   = 1'b1;
            e_rd_addr = sc_idx;
         end
         ST_SRC_WR: begin
            e_wr_en   = 1'b1;
            e_wr_addr = sc_idx;
         end
         ST_PRB_RD: begin
            e_rd_en   = 1'b1;
            e_rd_addr = prb_idx;
         end
         default: begin
         end
      endcase
   end

   // Magnetic RAM port control
   always_comb begin
      h_wr_en   = 1'b0;
      h_wr_addr = fdtd_pkg::idx_type'(pair32 - 32'd3);
      h_wr_data = alu_rsp.value;
      h_rd_en   = 1'b0;
      h_rd_addr = fdtd_pkg::idx_type'(pair32 - 32'd1);
      case (state_ff)
         ST_CLEAR: begin
            h_wr_en   = 1'b1;
            h_wr_addr = fdtd_pkg::idx_type'(cnt_ff);
            h_wr_data = '0;
         end
         ST_SWEEP: begin
            h_wr_en = h_wr_sw;
            h_rd_en = h_rd_sw;
         end
         ST_PRB_RD: begin
            h_rd_en   = 1'b1;
            h_rd_addr = prb_idx;
         end
         default: begin
         end
      endcase
   end

   fdtd_ram #(
      .WIDTH (fdtd_pkg::DATA_W),
      .DEPTH (fdtd_pkg::CELLS)
   ) u_e_ram (
      .clock   (clock),
      .wr_en   (e_wr_en),
      .wr_addr (e_wr_addr),
      .wr_data (e_wr_data),
      .rd_en   (e_rd_en),
      .rd_addr (e_rd_addr),
      .rd_data (e_rd_data)
   );

   fdtd_ram #(
      .WIDTH (fdtd_pkg::DATA_W),
      .DEPTH (fdtd_pkg::CELLS)
   ) u_h_ram (
      .clock   (clock),
      .wr_en   (h_wr_en),
      .wr_addr (h_wr_addr),
      .wr_data (h_wr_data),
      .rd_en   (h_rd_en),
      .rd_addr (h_rd_addr),
      .rd_data (h_rd_data)
   );

   // Requests to the shared unit; end cells go through with a zero difference
   always_comb begin
      alu_req.vld  = 1'b0;
      alu_req.diff = '0;
      alu_req.gain = '0;
      alu_req.base = '0;
      if (h_op) begin
         alu_req.vld  = 1'b1;
         alu_req.diff = h_pass ? '0 : diff_of(e_rd_data, e0_ff);
         alu_req.gain = cfg.h_gain;
         alu_req.base = h_rd_data;
      end else if (e_op) begin
         alu_req.vld  = 1'b1;
         alu_req.diff = e_pass ? '0 : diff_of(hcur_ff, hprev_ff);
         alu_req.gain = cfg.e_gain;
         alu_req.base = e2_ff;
      end else if (state_ff == ST_SRC_OP) begin
         alu_req.vld  = 1'b1;
         alu_req.diff = {src_ff[fdtd_pkg::DATA_W-1], src_ff};
         alu_req.gain = fdtd_pkg::UNITY_GAIN;
         alu_req.base = e_rd_data;
      end
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      adv_in   = adv_ff;
      src_in   = src_ff;
      prb_in   = prb_ff;
      sat_in   = sat_ff | alu_rsp.clip;
      case (state_ff)
         ST_CLEAR: begin
            cnt_in = cnt_ff + fdtd_pkg::cnt_type'(1);
            if (32'(cnt_ff) == 32'(fdtd_pkg::CELLS - 1)) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (item_valid) begin
               adv_in   = item_advance;
               src_in   = item_source;
               prb_in   = item_probe;
               sat_in   = 1'b0;
               cnt_in   = '0;
               state_in = item_advance ? ST_SWEEP : ST_PRB_RD;
            end
         end
         ST_SWEEP: begin
            cnt_in = cnt_ff + fdtd_pkg::cnt_type'(1);
            if (32'(cnt_ff) == 32'(fdtd_pkg::SWEEP_LAST)) begin
               cnt_in   = '0;
               state_in = src_ok ? ST_SRC_RD : ST_PRB_RD;
            end
         end
         ST_SRC_RD:   state_in = ST_SRC_OP;
         ST_SRC_OP:   state_in = ST_SRC_WAIT;
         ST_SRC_WAIT: state_in = ST_SRC_WR;
         ST_SRC_WR:   state_in = ST_PRB_RD;
         ST_PRB_RD:   state_in = ST_DONE;
         ST_DONE: begin
            if (out_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      adv_ff <= adv_in;
      src_ff <= src_in;
      prb_ff <= prb_in;
      sat_ff <= sat_in;
   end

   // old-E shift line, advanced on every even sweep slot
   always_ff @(posedge clock) begin
      if (sweep && !odd) begin
         e0_ff <= e_rd_data;
         e1_ff <= e0_ff;
         e2_ff <= e1_ff;
      end
   end

   // new-H pair, loaded as each H result retires
   always_ff @(posedge clock) begin
      if (h_wr_sw) begin
         hcur_ff  <= alu_rsp.value;
         hprev_ff <= hcur_ff;
      end
   end

   assign item_ready         = (state_ff == ST_IDLE);
   assign out_valid          = (state_ff == ST_DONE);
   assign out_data.electric  = prb_ok ? e_rd_data : '0;
   assign out_data.magnetic  = prb_ok ? h_rd_data : '0;
   assign out_data.saturated = sat_ff;

   // every unit result matches an earlier issue into the unit
   a_alu_latency: assert property (@(posedge clock) disable iff (reset)
      alu_rsp.vld |-> $past(alu_req.vld, 2))
      else $error("update unit result without matching issue");

   // every sweep write takes a live unit result
   a_sweep_wr_src: assert property (@(posedge clock) disable iff (reset)
      (e_wr_sw || h_wr_sw) |-> alu_rsp.vld)
      else $error("sweep write without unit result");

   // no read of an electric cell in the same cycle it is written
   a_e_port: assert property (@(posedge clock) disable iff (reset)
      (e_wr_en && e_rd_en) |-> (e_wr_addr != e_rd_addr))
      else $error("electric RAM read and write collide");

   // H and E updates alternate, never both retire in one cycle
   a_alternate: assert property (@(posedge clock) disable iff (reset)
      sweep |-> !(e_wr_en && h_wr_en))
      else $error("electric and magnetic writes in one sweep cycle");

   // read-only items never flag saturation
   a_ro_sat: assert property (@(posedge clock) disable iff (reset)
      (out_valid && !adv_ff) |-> !out_data.saturated)
      else $error("saturation flagged on read-only transfer");

endmodule

// ===== rtl/core/fdtd_1d_yee_field_update_top.sv =====
`timescale 1ns / 1ps
// Top level of the 1-D FDTD Yee field update block: register port, sequencer,
// shared update unit and the result register. Depends on fdtd_pkg and all fdtd_* modules.
//
//   channel  ports   handshake            transfer carries
//   -------  ------  -------------------  ------------------------------------------
//   request  req_*   req_valid/req_ready  advance, source_value, probe_cell
//   result   rsp_*   rsp_valid/rsp_ready  electric_value, magnetic_value, saturated
//   config   csr_*   psel/penable/pready  h_gain @0x0, e_gain @0x4, source_cell @0x8
//
// An advancing item loads the result register after the fused sweep, which issues two
// operations per cell into the one shared multiply/round/saturate unit, the source add
// (when source_cell is in range) and the probe read. A read-only item loads it after
// the probe read alone. The result transfer can follow in the cycle after the load.
// After reset a clearing pass writes zero to all CELLS entries of both cell RAMs;
// req_ready stays low during that pass while register writes are taken.
// One item is in flight at a time; the next request is taken while a result still
// waits in the output register, and a stalled rsp_ready holds the finished item.

module fdtd_1d_yee_field_update_top (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_advance,
   input  logic signed [31:0]                  req_source_value,
   input  logic [7:0]                          req_probe_cell,

   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [31:0]                  rsp_electric_value,
   output logic signed [31:0]                  rsp_magnetic_value,
   output logic                                rsp_saturated,

   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [fdtd_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [fdtd_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [fdtd_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   fdtd_pkg::cfg_type      cfg;
   fdtd_pkg::alu_req_type  alu_req;
   fdtd_pkg::alu_rsp_type  alu_rsp;
   fdtd_pkg::result_type   seq_out;
   logic                   seq_out_valid;
   logic                   slot_free;

   logic                   rsp_valid_ff, rsp_valid_in;
   fdtd_pkg::result_type   rsp_data_ff;

   fdtd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   fdtd_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .item_valid   (req_valid),
      .item_ready   (req_ready),
      .item_advance (req_advance),
      .item_source  (req_source_value),
      .item_probe   (req_probe_cell),
      .out_valid    (seq_out_valid),
      .out_ready    (slot_free),
      .out_data     (seq_out),
      .alu_req      (alu_req),
      .alu_rsp      (alu_rsp)
   );

   fdtd_alu u_alu (
      .clock (clock),
      .reset (reset),
      .req   (alu_req),
      .rsp   (alu_rsp)
   );

   // Result register: loads when empty or being drained in the same cycle
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (seq_out_valid && slot_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (seq_out_valid && slot_free) begin
         rsp_data_ff <= seq_out;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_electric_value = rsp_data_ff.electric;
   assign rsp_magnetic_value = rsp_data_ff.magnetic;
   assign rsp_saturated      = rsp_data_ff.saturated;

endmodule
